@@ design/vehicle_ready_to_drive_pedal_check_macros.svh @@
// assertion macros shared by the checker of the ready-to-drive block
`ifndef VEHICLE_READY_TO_DRIVE_PEDAL_CHECK_MACROS_SVH
`define VEHICLE_READY_TO_DRIVE_PEDAL_CHECK_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtd assertion failed");

`endif

@@ design/rtd_pkg.sv @@
// types, constants and register codes of the ready-to-drive pedal check
`timescale 1ns / 1ps
`default_nettype none

package rtd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int PEDAL_W       = 10;
    localparam int TORQUE_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIS_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIS_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd5;

    // register reset values
    localparam logic [9:0]  BRAKE_THR_RST = 10'd200;
    localparam logic [9:0]  MIS_LIMIT_RST = 10'd102;
    localparam logic [15:0] ARM_HOLD_RST  = 16'd2000;
    localparam logic [15:0] SOUND_RST     = 16'd2000;
    localparam logic [15:0] MIS_MS_RST    = 16'd100;

    // x / 33 == (x * DIV33_MUL) >> DIV33_SHIFT for x below 67650
    localparam logic [15:0] DIV33_MUL     = 16'd63551;
    localparam int          DIV33_SHIFT   = 21;
    // x / 1023 == (x * DIV1023_MUL) >> DIV1023_SHIFT for x below 69977
    localparam logic [16:0] DIV1023_MUL   = 17'd65601;
    localparam int          DIV1023_SHIFT = 26;
    localparam logic [15:0] TORQUE_MAX    = 16'd32767;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARM   = 2'd1,
        PH_SOUND = 2'd2,
        PH_DRIVE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [9:0]  brake_trip;
        logic [9:0]  mismatch_limit;
        logic [15:0] arm_hold_ms;
        logic [15:0] sound_ms;
        logic [15:0] mismatch_ms;
        logic        reverse_torque;
    } rtd_cfg_t;

    // classified sample handed from front end to back end
    typedef struct packed {
        logic        braked;
        logic        start;
        logic        mismatch;
        logic [14:0] torque_mag;
    } rtd_item_t;

endpackage

`default_nettype wire

@@ design/rtd_front.sv @@
// front end: takes samples, compares pedals and maps the torque magnitude
`timescale 1ns / 1ps
`default_nettype none

module rtd_front
    import rtd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rtd_cfg_t             cfg,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PEDAL_W-1:0]   pedal_main,
    input  wire logic [PEDAL_W-1:0]   pedal_aux,
    input  wire logic [PEDAL_W-1:0]   brake_level,
    input  wire logic                 start_pressed,
    input  wire logic [TIME_BITS-1:0] now_ms,
    input  wire logic                 q_full,
    output logic                      push,
    output rtd_item_t                 push_item,
    output logic [TIME_BITS-1:0]      push_now
);

    // stage 1: captured sample, aux times 50
    logic                 s1_valid_reg;
    logic [9:0]           s1_main_reg;
    logic [15:0]          s1_aux50_reg;
    logic                 s1_braked_reg;
    logic                 s1_start_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    // stage 2: scaled aux
    logic                 s2_valid_reg;
    logic [9:0]           s2_main_reg;
    logic [10:0]          s2_scaled_reg;
    logic                 s2_braked_reg;
    logic                 s2_start_reg;
    logic [TIME_BITS-1:0] s2_now_reg;

    // stage 3: average and mismatch flag
    logic                 s3_valid_reg;
    logic [10:0]          s3_avg_reg;
    logic [15:0]          s3_avg31_reg;
    logic                 s3_mismatch_reg;
    logic                 s3_braked_reg;
    logic                 s3_start_reg;
    logic [TIME_BITS-1:0] s3_now_reg;

    logic        load1;
    logic        load2;
    logic        load3;
    logic        accept;
    logic [15:0] aux50;
    logic [31:0] scale_prod;
    logic [10:0] main_ext;
    logic [10:0] diff;
    logic [11:0] pedal_sum;
    logic [10:0] avg;
    logic [15:0] avg31;
    logic [32:0] frac_prod;
    logic [6:0]  frac_q;
    logic [15:0] torque_raw;

    // a stage loads when empty or when its word moves on
    assign push     = s3_valid_reg && !q_full;
    assign load3    = !s3_valid_reg || push;
    assign load2    = !s2_valid_reg || load3;
    assign load1    = !s1_valid_reg || load2;
    assign in_stall = !load1;
    assign accept   = in_valid && load1;

    assign aux50 = {1'b0, pedal_aux, 5'b0} + {2'b0, pedal_aux, 4'b0} + {5'b0, pedal_aux, 1'b0};

    assign scale_prod = 32'(s1_aux50_reg) * 32'(DIV33_MUL);

    assign main_ext  = {1'b0, s2_main_reg};
    assign diff      = (main_ext > s2_scaled_reg) ? (main_ext - s2_scaled_reg)
                                                  : (s2_scaled_reg - main_ext);
    assign pedal_sum = {1'b0, main_ext} + {1'b0, s2_scaled_reg};
    assign avg       = pedal_sum[11:1];
    assign avg31     = {avg, 5'b0} - {5'b0, avg};

    // avg * 32767 / 1023 == avg * 32 + avg * 31 / 1023
    assign frac_prod  = 33'(s3_avg31_reg) * 33'(DIV1023_MUL);
    assign frac_q     = frac_prod[DIV1023_SHIFT+6:DIV1023_SHIFT];
    assign torque_raw = {s3_avg_reg, 5'b0} + {9'b0, frac_q};

    always_comb
    begin
        push_item.braked     = s3_braked_reg;
        push_item.start      = s3_start_reg;
        push_item.mismatch   = s3_mismatch_reg;
        push_item.torque_mag = (torque_raw > TORQUE_MAX) ? TORQUE_MAX[14:0] : torque_raw[14:0];
        push_now             = s3_now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (load2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_main_reg   <= pedal_main;
            s1_aux50_reg  <= aux50;
            s1_braked_reg <= brake_level > cfg.brake_trip;
            s1_start_reg  <= start_pressed;
            s1_now_reg    <= now_ms;
        end
        if (load2 && s1_valid_reg)
        begin
            s2_main_reg   <= s1_main_reg;
            s2_scaled_reg <= scale_prod[31:DIV33_SHIFT];
            s2_braked_reg <= s1_braked_reg;
            s2_start_reg  <= s1_start_reg;
            s2_now_reg    <= s1_now_reg;
        end
        if (load3 && s2_valid_reg)
        begin
            s3_avg_reg      <= avg;
            s3_avg31_reg    <= avg31;
            s3_mismatch_reg <= diff > {1'b0, cfg.mismatch_limit};
            s3_braked_reg   <= s2_braked_reg;
            s3_start_reg    <= s2_start_reg;
            s3_now_reg      <= s2_now_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/rtd_queue.sv @@
// two-word queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module rtd_queue
    import rtd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rtd_item_t            push_item,
    input  wire logic [TIME_BITS-1:0] push_now,
    input  wire logic                 pop,
    output logic                      q_full,
    output logic                      q_empty,
    output rtd_item_t                 head_item,
    output logic [TIME_BITS-1:0]      head_now
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    rtd_item_t            head_item_reg;
    logic [TIME_BITS-1:0] head_now_reg;
    rtd_item_t            tail_item_reg;
    logic [TIME_BITS-1:0] tail_now_reg;
    logic                 do_pop;

    assign do_pop    = pop && (count_reg != CNT_EMPTY);
    assign q_full    = (count_reg == CNT_FULL);
    assign q_empty   = (count_reg == CNT_EMPTY);
    assign head_item = head_item_reg;
    assign head_now  = head_now_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_EMPTY;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // head slot always holds the oldest word
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (count_reg == CNT_FULL)
            begin
                head_item_reg <= tail_item_reg;
                head_now_reg  <= tail_now_reg;
                if (push)
                begin
                    tail_item_reg <= push_item;
                    tail_now_reg  <= push_now;
                end
            end
            else if (push)
            begin
                head_item_reg <= push_item;
                head_now_reg  <= push_now;
            end
        end
        else if (push)
        begin
            if (count_reg == CNT_EMPTY)
            begin
                head_item_reg <= push_item;
                head_now_reg  <= push_now;
            end
            else if (count_reg == CNT_ONE)
            begin
                tail_item_reg <= push_item;
                tail_now_reg  <= push_now;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/rtd_back.sv @@
// back end: phase sequencer, mismatch timer and output register
`timescale 1ns / 1ps
`default_nettype none

module rtd_back
    import rtd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rtd_cfg_t             cfg,
    input  wire logic                 q_empty,
    input  wire rtd_item_t            head_item,
    input  wire logic [TIME_BITS-1:0] head_now,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      brake_light,
    output logic                      drive_lamp,
    output logic                      buzzer_on,
    output logic signed [TORQUE_W-1:0] torque_cmd,
    output logic [1:0]                phase_now
);

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [TIME_BITS-1:0]        phase_start_reg;
    logic [TIME_BITS-1:0]        phase_start_next;
    logic [TIME_BITS-1:0]        mis_start_reg;
    logic [TIME_BITS-1:0]        mis_start_next;
    logic                        mis_seen_reg;
    logic                        mis_seen_next;
    logic                        out_valid_reg;
    logic                        brake_light_reg;
    logic                        drive_lamp_reg;
    logic                        buzzer_on_reg;
    logic signed [TORQUE_W-1:0]  torque_cmd_reg;
    phase_t                      phase_now_reg;

    logic                        lamp;
    logic signed [TORQUE_W-1:0]  torque;
    logic                        fault;
    logic [TIME_BITS-1:0]        phase_elapsed;
    logic [TIME_BITS-1:0]        mis_origin;
    logic [TIME_BITS-1:0]        mis_elapsed;
    logic signed [TORQUE_W-1:0]  torque_pos;

    // one word per cycle whenever the output register is free
    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign phase_elapsed = head_now - phase_start_reg;
    assign mis_origin    = mis_seen_reg ? mis_start_reg : head_now;
    assign mis_elapsed   = head_now - mis_origin;
    assign torque_pos    = $signed({1'b0, head_item.torque_mag});

    always_comb
    begin
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        mis_start_next   = mis_start_reg;
        mis_seen_next    = mis_seen_reg;
        lamp             = 1'b0;
        torque           = '0;
        fault            = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (head_item.start && head_item.braked)
                begin
                    phase_next       = PH_ARM;
                    phase_start_next = head_now;
                end
            end
            PH_ARM:
            begin
                if (!head_item.start || !head_item.braked)
                begin
                    phase_next       = PH_IDLE;
                    phase_start_next = head_now;
                end
                else if (phase_elapsed >= TIME_BITS'(cfg.arm_hold_ms))
                begin
                    phase_next       = PH_SOUND;
                    phase_start_next = head_now;
                end
            end
            PH_SOUND:
            begin
                if (phase_elapsed >= TIME_BITS'(cfg.sound_ms))
                begin
                    phase_next       = PH_DRIVE;
                    phase_start_next = head_now;
                end
            end
            PH_DRIVE:
            begin
                lamp = 1'b1;
                if (head_item.mismatch)
                begin
                    mis_start_next = mis_origin;
                    mis_seen_next  = 1'b1;
                    fault          = mis_elapsed >= TIME_BITS'(cfg.mismatch_ms);
                end
                else
                begin
                    mis_seen_next = 1'b0;
                end
                if (fault)
                begin
                    phase_next       = PH_IDLE;
                    phase_start_next = head_now;
                    mis_seen_next    = 1'b0;
                end
                else
                begin
                    torque = cfg.reverse_torque ? -torque_pos : torque_pos;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_start_reg <= '0;
            mis_start_reg   <= '0;
            mis_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                phase_start_reg <= phase_start_next;
                mis_start_reg   <= mis_start_next;
                mis_seen_reg    <= mis_seen_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            brake_light_reg <= head_item.braked;
            drive_lamp_reg  <= lamp;
            buzzer_on_reg   <= (phase_next == PH_SOUND);
            torque_cmd_reg  <= torque;
            phase_now_reg   <= phase_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign brake_light = brake_light_reg;
    assign drive_lamp  = drive_lamp_reg;
    assign buzzer_on   = buzzer_on_reg;
    assign torque_cmd  = torque_cmd_reg;
    assign phase_now   = phase_now_reg;

endmodule

`default_nettype wire

@@ design/vehicle_ready_to_drive_pedal_check.sv @@
// top level of the ready-to-drive sequencer with pedal plausibility check
`timescale 1ns / 1ps
`default_nettype none

// Each sample word gives one result word. A three-stage front end compares the
// scaled auxiliary pedal with the main pedal and maps the pedal average to a
// torque magnitude; a two-word queue feeds the back end, which steps the phase
// (idle, arming, sounding, driving) and the mismatch timer once per word, which
// sets the sustained rate, and loads the output register. A new sample is taken
// every cycle while the result side keeps up; a result passes the front-end
// stages, queue and output register. Only the low TIME_BITS bits of now_ms are
// used and all time differences wrap at that width. The user must see that
// configuration is written through cfg_we, cfg_index and cfg_data only while no
// sample is in flight, not enforced by the block; unknown indexes are ignored.

module vehicle_ready_to_drive_pedal_check
    import rtd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [PEDAL_W-1:0]     pedal_main,
    input  wire logic [PEDAL_W-1:0]     pedal_aux,
    input  wire logic [PEDAL_W-1:0]     brake_level,
    input  wire logic                   start_pressed,
    input  wire logic [31:0]            now_ms,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        brake_light,
    output logic                        drive_lamp,
    output logic                        buzzer_on,
    output logic signed [TORQUE_W-1:0]  torque_cmd,
    output logic [1:0]                  phase_now
);

    rtd_cfg_t             cfg_reg;
    logic                 push;
    rtd_item_t            push_item;
    logic [TIME_BITS-1:0] push_now;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    rtd_item_t            head_item;
    logic [TIME_BITS-1:0] head_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_trip      <= BRAKE_THR_RST;
            cfg_reg.mismatch_limit  <= MIS_LIMIT_RST;
            cfg_reg.arm_hold_ms     <= ARM_HOLD_RST;
            cfg_reg.sound_ms        <= SOUND_RST;
            cfg_reg.mismatch_ms     <= MIS_MS_RST;
            cfg_reg.reverse_torque  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRAKE_THR: cfg_reg.brake_trip      <= cfg_data[9:0];
                REG_MIS_LIMIT: cfg_reg.mismatch_limit  <= cfg_data[9:0];
                REG_ARM_HOLD:  cfg_reg.arm_hold_ms     <= cfg_data;
                REG_SOUND:     cfg_reg.sound_ms        <= cfg_data;
                REG_MIS_MS:    cfg_reg.mismatch_ms     <= cfg_data;
                REG_REVERSE:   cfg_reg.reverse_torque  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rtd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pedal_main    (pedal_main),
        .pedal_aux     (pedal_aux),
        .brake_level   (brake_level),
        .start_pressed (start_pressed),
        .now_ms        (now_ms[TIME_BITS-1:0]),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item),
        .push_now      (push_now)
    );

    rtd_queue #(
        .TIME_BITS (TIME_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_now  (push_now),
        .pop       (pop),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .head_item (head_item),
        .head_now  (head_now)
    );

    rtd_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .head_item   (head_item),
        .head_now    (head_now),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .brake_light (brake_light),
        .drive_lamp  (drive_lamp),
        .buzzer_on   (buzzer_on),
        .torque_cmd  (torque_cmd),
        .phase_now   (phase_now)
    );

endmodule

`default_nettype wire

@@ design/rtd_checker.sv @@
// port-level checks of the ready-to-drive block and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "vehicle_ready_to_drive_pedal_check_macros.svh"

module rtd_checker
    import rtd_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic                   drive_lamp,
    input wire logic                   buzzer_on,
    input wire logic signed [TORQUE_W-1:0] torque_cmd,
    input wire logic [1:0]             phase_now
);

    logic torque_nz;
    logic left_drive;

    assign torque_nz  = (torque_cmd != 16'sd0);
    assign left_drive = out_valid && drive_lamp && (phase_now != PH_DRIVE);

    // a stalled result word stays offered
    `RTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // torque only comes from a word handled while driving that stayed driving
    `RTD_ASSERT_NOW(a_torque_drive, out_valid && torque_nz, drive_lamp && phase_now == PH_DRIVE)

    // buzzer follows the sounding phase
    `RTD_ASSERT_NOW(a_buzzer_phase, out_valid, buzzer_on == (phase_now == PH_SOUND))

    // leaving driving is only the fault exit to idle with zero torque
    `RTD_ASSERT_NOW(a_fault_exit, left_drive, phase_now == PH_IDLE && !torque_nz)

endmodule

bind vehicle_ready_to_drive_pedal_check rtd_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/rtd_drive_monitor.sv @@
// watches the sample and result channels of the ready-to-drive block, predicts and compares
`timescale 1ns / 1ps

module rtd_drive_monitor
    import rtd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [PEDAL_W-1:0]          pedal_main,
    input  logic [PEDAL_W-1:0]          pedal_aux,
    input  logic [PEDAL_W-1:0]          brake_level,
    input  logic                        start_pressed,
    input  logic [31:0]                 now_ms,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        brake_light,
    input  logic                        drive_lamp,
    input  logic                        buzzer_on,
    input  logic signed [TORQUE_W-1:0]  torque_cmd,
    input  logic [1:0]                  phase_now,
    output int                          mismatches,
    output int                          outstanding,
    output int                          results_checked,
    output int                          drive_entries,
    output int                          fault_exits
);

    typedef struct packed {
        logic                brake_light;
        logic                drive_lamp;
        logic                buzzer_on;
        logic [TORQUE_W-1:0] torque;
        logic [1:0]          phase;
    } rtd_result_t;

    rtd_cfg_t    regs;
    phase_t      seq_phase;
    logic [31:0] phase_since;
    logic [31:0] mis_since;
    logic        mis_active;
    rtd_result_t predicted_outputs[$];

    // one sample through the sequencer; updates the shadow state
    function automatic rtd_result_t step_sequencer(
        input logic [9:0]  pm,
        input logic [9:0]  pa,
        input logic [9:0]  bl,
        input logic        st,
        input logic [31:0] now
    );
        rtd_result_t r;
        logic        braked;
        logic        fault;
        logic [31:0] scaled;
        logic [31:0] spread;
        logic [31:0] avg;
        logic [31:0] mag;
        r = '0;
        braked = bl > regs.brake_trip;
        case (seq_phase)
            PH_IDLE:
            begin
                if (st && braked)
                begin
                    seq_phase = PH_ARM;
                    phase_since = now;
                end
            end
            PH_ARM:
            begin
                if (!st || !braked)
                begin
                    seq_phase = PH_IDLE;
                    phase_since = now;
                end
                else if (now - phase_since >= {16'd0, regs.arm_hold_ms})
                begin
                    seq_phase = PH_SOUND;
                    phase_since = now;
                end
            end
            PH_SOUND:
            begin
                if (now - phase_since >= {16'd0, regs.sound_ms})
                begin
                    seq_phase = PH_DRIVE;
                    phase_since = now;
                end
            end
            default:
            begin
                r.drive_lamp = 1'b1;
                fault = 1'b0;
                scaled = ({22'd0, pa} * 32'd50) / 32'd33;
                spread = ({22'd0, pm} > scaled) ? {22'd0, pm} - scaled : scaled - {22'd0, pm};
                if (spread > {22'd0, regs.mismatch_limit})
                begin
                    if (!mis_active)
                    begin
                        mis_since = now;
                        mis_active = 1'b1;
                    end
                    if (now - mis_since >= {16'd0, regs.mismatch_ms})
                        fault = 1'b1;
                end
                else
                    mis_active = 1'b0;
                if (fault)
                begin
                    seq_phase = PH_IDLE;
                    phase_since = now;
                    mis_active = 1'b0;
                end
                else
                begin
                    avg = ({22'd0, pm} + scaled) >> 1;
                    mag = (avg * 32'd32767) / 32'd1023;
                    // the mapped average can overshoot full scale
                    if (mag > {16'd0, TORQUE_MAX})
                        mag = {16'd0, TORQUE_MAX};
                    r.torque = regs.reverse_torque ? -mag[15:0] : mag[15:0];
                end
            end
        endcase
        r.brake_light = braked;
        r.buzzer_on = (seq_phase == PH_SOUND);
        r.phase = seq_phase;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rtd_result_t want;
        rtd_result_t got;
        phase_t      prev;
        if (!rst_n)
        begin
            regs.brake_trip = BRAKE_THR_RST;
            regs.mismatch_limit = MIS_LIMIT_RST;
            regs.arm_hold_ms = ARM_HOLD_RST;
            regs.sound_ms = SOUND_RST;
            regs.mismatch_ms = MIS_MS_RST;
            regs.reverse_torque = 1'b0;
            seq_phase = PH_IDLE;
            phase_since = '0;
            mis_since = '0;
            mis_active = 1'b0;
            predicted_outputs.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BRAKE_THR: regs.brake_trip = cfg_data[9:0];
                    REG_MIS_LIMIT: regs.mismatch_limit = cfg_data[9:0];
                    REG_ARM_HOLD:  regs.arm_hold_ms = cfg_data;
                    REG_SOUND:     regs.sound_ms = cfg_data;
                    REG_MIS_MS:    regs.mismatch_ms = cfg_data;
                    REG_REVERSE:   regs.reverse_torque = cfg_data[0];
                    default:       ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = {brake_light, drive_lamp, buzzer_on, torque_cmd, phase_now};
                if (predicted_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing predicted: %h", $realtime, got);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d differs", $realtime, results_checked);
                            $display("  want brake %b lamp %b buzz %b torque %0d phase %0d",
                                     want.brake_light, want.drive_lamp, want.buzzer_on,
                                     $signed(want.torque), want.phase);
                            $display("  got  brake %b lamp %b buzz %b torque %0d phase %0d",
                                     got.brake_light, got.drive_lamp, got.buzzer_on,
                                     $signed(got.torque), got.phase);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                prev = seq_phase;
                want = step_sequencer(pedal_main, pedal_aux, brake_level, start_pressed, now_ms);
                if (prev == PH_SOUND && seq_phase == PH_DRIVE)
                    drive_entries++;
                if (prev == PH_DRIVE && seq_phase == PH_IDLE)
                    fault_exits++;
                predicted_outputs.push_back(want);
            end
            outstanding = predicted_outputs.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// stimulus and verdict for the ready-to-drive sequencer with pedal plausibility check
`timescale 1ns / 1ps

module testbench
    import rtd_pkg::*;
();

    localparam int IDLE_CYCLE_LIMIT  = 3000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_SETTINGS   = 8;
    localparam int WORDS_PER_SETTING = 125;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
    // start just below the 32-bit wrap so the hold times cross it
    localparam logic [31:0] T_WRAP = 32'hFFFF_FA00;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [PEDAL_W-1:0]         pedal_main;
    logic [PEDAL_W-1:0]         pedal_aux;
    logic [PEDAL_W-1:0]         brake_level;
    logic                       start_pressed;
    logic [31:0]                now_ms;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       brake_light;
    logic                       drive_lamp;
    logic                       buzzer_on;
    logic signed [TORQUE_W-1:0] torque_cmd;
    logic [1:0]                 phase_now;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          drive_entries;
    int          fault_exits;
    int          gap_max = 0;
    int          stall_max = 0;
    int          stall_left = 0;
    int          samples_sent = 0;
    int          settings_used = 1;
    int          idle_cycles = 0;
    logic        res_taken;
    logic [31:0] clock_ms;
    logic [9:0]  thr_shadow = BRAKE_THR_RST;
    logic [15:0] arm_shadow = ARM_HOLD_RST;
    logic [15:0] sound_shadow = SOUND_RST;
    logic [15:0] mis_shadow = MIS_MS_RST;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    vehicle_ready_to_drive_pedal_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pedal_main    (pedal_main),
        .pedal_aux     (pedal_aux),
        .brake_level   (brake_level),
        .start_pressed (start_pressed),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .brake_light   (brake_light),
        .drive_lamp    (drive_lamp),
        .buzzer_on     (buzzer_on),
        .torque_cmd    (torque_cmd),
        .phase_now     (phase_now)
    );

    rtd_drive_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pedal_main      (pedal_main),
        .pedal_aux       (pedal_aux),
        .brake_level     (brake_level),
        .start_pressed   (start_pressed),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .brake_light     (brake_light),
        .drive_lamp      (drive_lamp),
        .buzzer_on       (buzzer_on),
        .torque_cmd      (torque_cmd),
        .phase_now       (phase_now),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .drive_entries   (drive_entries),
        .fault_exits     (fault_exits)
    );

    // result side: a fresh stall count is drawn after every word taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_taken <= 1'b0;
        else
            res_taken <= out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (res_taken)
                stall_left = $urandom_range(0, stall_max);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_CYCLE_LIMIT)
        begin
            $display("no word moved for %0d cycles, giving up", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(
        input logic [9:0]  m,
        input logic [9:0]  a,
        input logic [9:0]  b,
        input logic        s,
        input logic [31:0] t
    );
        int gap;
        // every 40 words pick a new pace, sometimes with no idling at all
        if (samples_sent % 40 == 0)
        begin
            gap_max = $urandom_range(0, 1) ? 16 : 0;
            stall_max = $urandom_range(0, 1) ? 16 : 0;
        end
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pedal_main <= m;
        pedal_aux <= a;
        brake_level <= b;
        start_pressed <= s;
        now_ms <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    // wait until every predicted word is back and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
    endtask

    task automatic program_regs(
        input logic [15:0] thr,
        input logic [15:0] lim,
        input logic [15:0] arm,
        input logic [15:0] snd,
        input logic [15:0] mis,
        input logic        rev
    );
        put_reg(REG_BRAKE_THR, thr);
        put_reg(REG_MIS_LIMIT, lim);
        put_reg(REG_ARM_HOLD, arm);
        put_reg(REG_SOUND, snd);
        put_reg(REG_MIS_MS, mis);
        put_reg(REG_REVERSE, {15'($urandom), rev});
        // writes to unmapped indexes must leave everything alone
        put_reg(REG_UNUSED_6, 16'($urandom));
        put_reg(REG_UNUSED_7, 16'($urandom));
        cfg_we <= 1'b0;
        thr_shadow = thr[9:0];
        arm_shadow = arm;
        sound_shadow = snd;
        mis_shadow = mis;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_hold();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(100, 3000));
            default: return 16'($urandom_range(1, 30));
        endcase
    endfunction

    // time advance scaled to the hold in force, with rare arbitrary jumps
    function automatic logic [31:0] ms_advance(input int hold);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return $urandom_range(0, hold / 2 + 2);
    endfunction

    function automatic logic [9:0] brake_for(input logic press);
        if (!press)
            return 10'($urandom_range(0, thr_shadow));
        if (thr_shadow != 10'h3FF)
            return 10'($urandom_range(thr_shadow + 1, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    // button and brake held, buzzer wait, then a stretch of driving
    task automatic drive_attempt();
        int         n;
        logic       bad;
        logic [9:0] m;
        logic [9:0] a;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            clock_ms += ms_advance(arm_shadow);
            send_word(10'($urandom), 10'($urandom), brake_for($urandom_range(0, 9) != 0),
                      $urandom_range(0, 19) != 0, clock_ms);
        end
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            clock_ms += ms_advance(sound_shadow);
            send_word(10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom), clock_ms);
        end
        n = $urandom_range(3, 16);
        bad = 1'b0;
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
                bad = !bad;
            m = 10'($urandom);
            // aux tracks main at 33/50 unless in a disagreement stretch
            if (bad)
                a = 10'($urandom);
            else
                a = 10'((int'(m) * 33) / 50 + $urandom_range(0, 1));
            clock_ms += ms_advance(mis_shadow);
            send_word(m, a, 10'($urandom), 1'($urandom), clock_ms);
        end
    endtask

    initial
    begin
        int target;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pedal_main = '0;
        pedal_aux = '0;
        brake_level = '0;
        start_pressed = 1'b0;
        now_ms = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: full walk to driving, saturation, pedal fault
        send_word(10'd0, 10'd0, 10'd0, 1'b1, T_WRAP - 32'd10);
        send_word(10'd1023, 10'd1023, 10'd1023, 1'b0, T_WRAP - 32'd5);
        send_word(10'd5, 10'd5, 10'd200, 1'b1, T_WRAP - 32'd1);
        send_word(10'd5, 10'd5, 10'd201, 1'b1, T_WRAP);
        send_word(10'd5, 10'd5, 10'd1023, 1'b1, T_WRAP + 32'd1000);
        send_word(10'd5, 10'd5, 10'd1023, 1'b1, T_WRAP + 32'd2000);
        send_word(10'd5, 10'd5, 10'd0, 1'b0, T_WRAP + 32'd3000);
        send_word(10'd5, 10'd5, 10'd0, 1'b0, T_WRAP + 32'd4000);
        send_word(10'd1023, 10'd1023, 10'd0, 1'b0, T_WRAP + 32'd4001);
        send_word(10'd0, 10'd0, 10'd0, 1'b0, T_WRAP + 32'd4050);
        send_word(10'd1023, 10'd675, 10'd0, 1'b0, T_WRAP + 32'd4060);
        send_word(10'd0, 10'd1023, 10'd0, 1'b0, T_WRAP + 32'd4100);
        send_word(10'd0, 10'd1023, 10'd0, 1'b0, T_WRAP + 32'd4199);
        send_word(10'd0, 10'd1023, 10'd0, 1'b0, T_WRAP + 32'd4200);

        // all registers at their low end, torque reversed
        settle();
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        clock_ms = 32'd77;
        send_word(10'd0, 10'd0, 10'd0, 1'b1, clock_ms);
        send_word(10'd0, 10'd0, 10'd1, 1'b1, clock_ms);
        send_word(10'd0, 10'd0, 10'd1, 1'b1, clock_ms);
        send_word(10'd0, 10'd0, 10'd1, 1'b1, clock_ms);
        send_word(10'd3, 10'd2, 10'd1, 1'b1, clock_ms);
        send_word(10'd1023, 10'd1023, 10'd1, 1'b1, clock_ms);

        for (int k = 0; k < RANDOM_SETTINGS; k++)
        begin
            settle();
            if (k == 0)
                program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
            else
                program_regs(16'($urandom),
                             $urandom_range(0, 1) ? 16'($urandom_range(0, 60)) : 16'($urandom),
                             pick_hold(), pick_hold(), pick_hold(), 1'($urandom));
            if (k % 3 == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            target = samples_sent + WORDS_PER_SETTING;
            while (samples_sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    drive_attempt();
                else
                    repeat ($urandom_range(1, 5))
                    begin
                        clock_ms += ms_advance(arm_shadow);
                        send_word(10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                                  clock_ms);
                    end
            end
        end

        settle();
        $display("%0d samples sent under %0d register settings, %0d results checked",
                 samples_sent, settings_used, results_checked);
        $display("driving entered %0d times, left on a pedal disagreement %0d times",
                 drive_entries, fault_exits);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ vehicle_ready_to_drive_pedal_check.f @@
+incdir+design
design/rtd_pkg.sv
design/rtd_front.sv
design/rtd_queue.sv
design/rtd_back.sv
design/vehicle_ready_to_drive_pedal_check.sv
design/rtd_checker.sv
tb/sv/rtd_drive_monitor.sv
tb/sv/testbench.sv
